// File: src/sed_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge detector package
// Shared constants, register codes and the result record of the edge detector.
// ----------------------------------------------------------------------------
package sed_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int PIX_W      = 8;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 16;
   localparam int CFG_W_W    = 11;
   localparam int CFG_H_W    = 16;
   localparam int CFG_T_W    = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int LINE_W     = 2 * PIX_W;
   localparam int RSP_DEPTH  = 3;

   localparam logic [CFG_W_W-1:0] WIDTH_RESET     = 11'd320;
   localparam logic [CFG_H_W-1:0] HEIGHT_RESET    = 16'd240;
   localparam logic [CFG_T_W-1:0] THRESHOLD_RESET = 8'd0;
   localparam logic [CFG_W_W-1:0] WIDTH_MIN       = 11'd3;
   localparam logic [CFG_W_W-1:0] WIDTH_MAX       = CFG_W_W'(MAX_WIDTH);
   localparam logic [CFG_H_W-1:0] HEIGHT_MIN      = 16'd3;

   typedef enum logic [1:0] {
      REG_WIDTH     = 2'd0,
      REG_HEIGHT    = 2'd1,
      REG_THRESHOLD = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_value;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             frame_last;
   } rsp_type;

endpackage

// File: src/sed_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read; a read and a write
// to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module sed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sobel_edge_detect.sv
// ----------------------------------------------------------------------------
// Sobel edge detector, 3x3 window over a raster pixel stream
// A result is registered at acceptance and in the result queue, then shown on
// rsp_valid. One pixel per cycle while req_stall is low; the two line stores
// share one RAM word read at acceptance, written next cycle, with forwarding.
// Reset: synchronous; clears counters, window and queue, loads register
// defaults. Line store contents are undefined until written.
// ----------------------------------------------------------------------------
module sobel_edge_detect (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sed_pkg::PIX_W-1:0]     req_pixel,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sed_pkg::PIX_W-1:0]     rsp_edge_value,
   output logic [sed_pkg::ROW_W-1:0]     rsp_out_row,
   output logic [sed_pkg::COL_W-1:0]     rsp_out_col,
   output logic                          rsp_frame_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sed_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sed_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sed_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);

   // Configuration registers
   logic [sed_pkg::CFG_W_W-1:0] width_ff;
   logic [sed_pkg::CFG_H_W-1:0] height_ff;
   logic [sed_pkg::CFG_T_W-1:0] thresh_ff;
   sed_pkg::csr_reg_type        csr_reg;
   logic                        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg    = sed_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sed_pkg::WIDTH_RESET;
         height_ff <= sed_pkg::HEIGHT_RESET;
         thresh_ff <= sed_pkg::THRESHOLD_RESET;
      end else if (csr_wr) begin
         unique case (csr_reg)
            sed_pkg::REG_WIDTH: begin
               width_ff <= csr_pwdata[sed_pkg::CFG_W_W-1:0];
            end
            sed_pkg::REG_HEIGHT: begin
               height_ff <= csr_pwdata[sed_pkg::CFG_H_W-1:0];
            end
            sed_pkg::REG_THRESHOLD: begin
               thresh_ff <= csr_pwdata[sed_pkg::CFG_T_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         sed_pkg::REG_WIDTH:     csr_prdata = sed_pkg::CSR_DATA_W'(width_ff);
         sed_pkg::REG_HEIGHT:    csr_prdata = sed_pkg::CSR_DATA_W'(height_ff);
         sed_pkg::REG_THRESHOLD: csr_prdata = sed_pkg::CSR_DATA_W'(thresh_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // Effective geometry
   logic [sed_pkg::CFG_W_W-1:0] w_eff;
   logic [sed_pkg::CFG_H_W-1:0] h_eff;

   always_comb begin
      if (width_ff < sed_pkg::WIDTH_MIN) begin
         w_eff = sed_pkg::WIDTH_MIN;
      end else if (width_ff > sed_pkg::WIDTH_MAX) begin
         w_eff = sed_pkg::WIDTH_MAX;
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < sed_pkg::HEIGHT_MIN) ? sed_pkg::HEIGHT_MIN : height_ff;
   end

   // Acceptance stage: position tracking and line store read
   logic                        req_accept;
   logic [sed_pkg::COL_W-1:0]   col_ff, col_in, col_cur;
   logic [sed_pkg::ROW_W-1:0]   row_ff, row_in, row_cur;
   logic                        emit_cur, last_cur;

   logic                        s1_valid_ff;
   logic [sed_pkg::PIX_W-1:0]   s1_pixel_ff;
   logic [sed_pkg::COL_W-1:0]   s1_col_ff;
   logic [sed_pkg::ROW_W-1:0]   s1_row_ff;
   logic                        s1_emit_ff;
   logic                        s1_last_ff;
   logic                        fwd_hit_ff;
   logic [sed_pkg::LINE_W-1:0]  fwd_data_ff;

   logic [1:0]                  q_count_ff;

   assign req_stall  = ({1'b0, q_count_ff} + {2'b00, s1_valid_ff})
                       >= 3'(sed_pkg::RSP_DEPTH);
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      emit_cur = (row_cur >= 16'd2) && (col_cur >= 10'd2) && (row_cur < h_eff)
                 && ({1'b0, col_cur} < w_eff);
      last_cur = (row_cur == h_eff - 16'd1) && ({1'b0, col_cur} == w_eff - 11'd1);
      if (({1'b0, col_cur} + 11'd1) >= w_eff) begin
         col_in = '0;
         if (({1'b0, row_cur} + 17'd1) >= {1'b0, h_eff}) begin
            row_in = '0;
         end else begin
            row_in = row_cur + 16'd1;
         end
      end else begin
         col_in = col_cur + 10'd1;
         row_in = row_cur;
      end
   end

   // Line store: upper byte is the older row, lower byte the previous row
   logic [sed_pkg::LINE_W-1:0]  ram_rd_data;
   logic [sed_pkg::LINE_W-1:0]  line_word;
   logic [sed_pkg::LINE_W-1:0]  ram_wr_data;
   logic [sed_pkg::PIX_W-1:0]   top, mid, bot;

   assign line_word   = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign top         = line_word[sed_pkg::LINE_W-1:sed_pkg::PIX_W];
   assign mid         = line_word[sed_pkg::PIX_W-1:0];
   assign bot         = s1_pixel_ff;
   assign ram_wr_data = {mid, bot};

   sed_ram #(
      .WIDTH (sed_pkg::LINE_W),
      .DEPTH (sed_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_addr (col_cur),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
      if (req_accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_cur;
         s1_row_ff   <= row_cur;
         s1_emit_ff  <= emit_cur;
         s1_last_ff  <= last_cur;
         fwd_hit_ff  <= s1_valid_ff && (s1_col_ff == col_cur);
         fwd_data_ff <= ram_wr_data;
      end
   end

   // Window and Sobel magnitude
   logic [sed_pkg::PIX_W-1:0]   win_ff [6];
   logic signed [11:0]          p0, p1, p2, p3, p5, p6, p7, p8;
   logic signed [11:0]          gx, gy;
   logic [10:0]                 abs_x, abs_y, mag_sum;
   logic [7:0]                  mag_sat;
   sed_pkg::rsp_type            s1_rsp;

   always_comb begin
      p0 = $signed({4'b0000, win_ff[0]});
      p3 = $signed({4'b0000, win_ff[1]});
      p6 = $signed({4'b0000, win_ff[2]});
      p1 = $signed({4'b0000, win_ff[3]});
      p7 = $signed({4'b0000, win_ff[5]});
      p2 = $signed({4'b0000, top});
      p5 = $signed({4'b0000, mid});
      p8 = $signed({4'b0000, bot});
      gx = (p2 - p0) + (p8 - p6) + ((p5 - p3) <<< 1);
      gy = (p0 - p6) + (p2 - p8) + ((p1 - p7) <<< 1);
      abs_x = gx[11] ? 11'(-gx) : 11'(gx);
      abs_y = gy[11] ? 11'(-gy) : 11'(gy);
      mag_sum = abs_x + abs_y;
      mag_sat = mag_sum[10] ? 8'hFF : mag_sum[9:2];
      s1_rsp.edge_value = (mag_sat > thresh_ff) ? mag_sat : '0;
      s1_rsp.out_row    = s1_row_ff - 16'd1;
      s1_rsp.out_col    = s1_col_ff - 10'd1;
      s1_rsp.frame_last = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

   // Result queue
   sed_pkg::rsp_type            q_ff [sed_pkg::RSP_DEPTH];
   logic [1:0]                  q_wr_ptr_ff, q_rd_ptr_ff;
   logic                        q_push, q_pop;
   sed_pkg::rsp_type            q_head;

   assign q_push    = s1_valid_ff & s1_emit_ff;
   assign rsp_valid = (q_count_ff != 2'd0);
   assign q_pop     = rsp_valid & ~rsp_stall;
   assign q_head    = q_ff[q_rd_ptr_ff];

   assign rsp_edge_value = q_head.edge_value;
   assign rsp_out_row    = q_head.out_row;
   assign rsp_out_col    = q_head.out_col;
   assign rsp_frame_last = q_head.frame_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff  <= '0;
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
      end else begin
         if (q_push) begin
            q_wr_ptr_ff <= (q_wr_ptr_ff == 2'(sed_pkg::RSP_DEPTH - 1)) ? 2'd0
                           : q_wr_ptr_ff + 2'd1;
         end
         if (q_pop) begin
            q_rd_ptr_ff <= (q_rd_ptr_ff == 2'(sed_pkg::RSP_DEPTH - 1)) ? 2'd0
                           : q_rd_ptr_ff + 2'd1;
         end
         if (q_push && !q_pop) begin
            q_count_ff <= q_count_ff + 2'd1;
         end else if (!q_push && q_pop) begin
            q_count_ff <= q_count_ff - 2'd1;
         end
      end
      if (q_push) begin
         q_ff[q_wr_ptr_ff] <= s1_rsp;
      end
   end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Sobel edge detector testbench
// Streams grey pixels through the edge detector over many frame geometries and
// thresholds, predicts every edge result in a scoreboard and checks each
// result transaction against it, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 800;
   localparam int SETTLE       = 8;
   localparam int WIDE_WIDTH   = 160;

   class edge_scoreboard;
      logic [sed_pkg::PIX_W-1:0] line_prev[sed_pkg::MAX_WIDTH];
      logic [sed_pkg::PIX_W-1:0] line_older[sed_pkg::MAX_WIDTH];
      bit                        prev_known[sed_pkg::MAX_WIDTH];
      bit                        older_known[sed_pkg::MAX_WIDTH];
      logic [sed_pkg::PIX_W-1:0] win[6];
      bit                        win_known[6];
      int unsigned               col;
      int unsigned               row;
      int unsigned               cfg_width;
      int unsigned               cfg_height;
      int unsigned               cfg_threshold;
      sed_pkg::rsp_type          pending[$];
      int unsigned               mismatches;

      function new();
         for (int i = 0; i < sed_pkg::MAX_WIDTH; i++) begin
            prev_known[i]  = 1'b0;
            older_known[i] = 1'b0;
         end
         for (int i = 0; i < 6; i++) begin
            win[i]       = '0;
            win_known[i] = 1'b1;
         end
         col           = 0;
         row           = 0;
         cfg_width     = 32'(sed_pkg::WIDTH_RESET);
         cfg_height    = 32'(sed_pkg::HEIGHT_RESET);
         cfg_threshold = 32'(sed_pkg::THRESHOLD_RESET);
         mismatches    = 0;
      endfunction

      function void write_reg(sed_pkg::csr_reg_type r,
                              logic [sed_pkg::CSR_DATA_W-1:0] v);
         case (r)
            sed_pkg::REG_WIDTH:     cfg_width     = 32'(v[sed_pkg::CFG_W_W-1:0]);
            sed_pkg::REG_HEIGHT:    cfg_height    = 32'(v[sed_pkg::CFG_H_W-1:0]);
            sed_pkg::REG_THRESHOLD: cfg_threshold = 32'(v[sed_pkg::CFG_T_W-1:0]);
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         if (cfg_width < 32'(sed_pkg::WIDTH_MIN)) return 32'(sed_pkg::WIDTH_MIN);
         if (cfg_width > sed_pkg::MAX_WIDTH) return sed_pkg::MAX_WIDTH;
         return cfg_width;
      endfunction

      function int unsigned eff_height();
         return (cfg_height < 32'(sed_pkg::HEIGHT_MIN)) ? 32'(sed_pkg::HEIGHT_MIN)
                                                        : cfg_height;
      endfunction

      // True when this pixel would produce a result from line store data that
      // was never written.
      function bit reads_unwritten(bit fs);
         int unsigned c;
         int unsigned r;
         bit          known;
         c = fs ? 0 : col;
         r = fs ? 0 : row;
         if (!(r >= 2 && c >= 2 && r < eff_height() && c < eff_width())) return 1'b0;
         known = prev_known[c % sed_pkg::MAX_WIDTH] && older_known[c % sed_pkg::MAX_WIDTH];
         for (int i = 0; i < 6; i++) known = known && win_known[i];
         return !known;
      endfunction

      function void note_pixel(logic [sed_pkg::PIX_W-1:0] pix, bit fs);
         int unsigned               w;
         int unsigned               h;
         int unsigned               idx;
         int                        p0, p1, p2, p3, p5, p6, p7, p8, gx, gy;
         int unsigned               mag;
         logic [sed_pkg::PIX_W-1:0] top;
         logic [sed_pkg::PIX_W-1:0] mid;
         bit                        top_known;
         bit                        mid_known;
         sed_pkg::rsp_type          want;
         w = eff_width();
         h = eff_height();
         if (fs) begin
            col = 0;
            row = 0;
         end
         idx       = col % sed_pkg::MAX_WIDTH;
         top       = line_older[idx];
         mid       = line_prev[idx];
         top_known = older_known[idx];
         mid_known = prev_known[idx];
         if (row >= 2 && col >= 2 && row < h && col < w) begin
            p0 = int'(win[0]); p3 = int'(win[1]); p6 = int'(win[2]);
            p1 = int'(win[3]); p7 = int'(win[5]);
            p2 = int'(top);    p5 = int'(mid);    p8 = int'(pix);
            gx = (p2 - p0) + (p8 - p6) + 2 * (p5 - p3);
            gy = (p0 - p6) + (p2 - p8) + 2 * (p1 - p7);
            mag = 32'(((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy)) >> 2);
            if (mag > 255) mag = 255;
            if (mag <= cfg_threshold) mag = 0;
            want.edge_value = mag[sed_pkg::PIX_W-1:0];
            want.out_row    = sed_pkg::ROW_W'(row - 1);
            want.out_col    = sed_pkg::COL_W'(col - 1);
            want.frame_last = (row == h - 1) && (col == w - 1);
            pending.push_back(want);
         end
         line_older[idx]  = mid;
         older_known[idx] = mid_known;
         line_prev[idx]   = pix;
         prev_known[idx]  = 1'b1;
         for (int i = 0; i < 3; i++) begin
            win[i]       = win[i + 3];
            win_known[i] = win_known[i + 3];
         end
         win[3] = top; win[4] = mid; win[5] = pix;
         win_known[3] = top_known; win_known[4] = mid_known; win_known[5] = 1'b1;
         if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : (row + 1) & 32'h0000FFFF;
         end else begin
            col = col + 1;
         end
      endfunction

      function void check_result(sed_pkg::rsp_type got);
         sed_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %0d row %0d col %0d last %0d",
                        got.edge_value, got.out_row, got.out_col, got.frame_last);
            return;
         end
         want = pending.pop_front();
         if (got.edge_value !== want.edge_value || got.out_row !== want.out_row ||
             got.out_col !== want.out_col || got.frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected value %0d row %0d col %0d last %0d, ",
                         "got %0d %0d %0d %0d"},
                        want.edge_value, want.out_row, want.out_col, want.frame_last,
                        got.edge_value, got.out_row, got.out_col, got.frame_last);
         end
      endfunction
   endclass

   logic                           clock           = 1'b0;
   logic                           reset           = 1'b1;
   logic                           req_valid       = 1'b0;
   logic                           req_stall;
   logic [sed_pkg::PIX_W-1:0]      req_pixel       = '0;
   logic                           req_frame_start = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall       = 1'b0;
   logic [sed_pkg::PIX_W-1:0]      rsp_edge_value;
   logic [sed_pkg::ROW_W-1:0]      rsp_out_row;
   logic [sed_pkg::COL_W-1:0]      rsp_out_col;
   logic                           rsp_frame_last;
   logic                           csr_psel        = 1'b0;
   logic                           csr_penable     = 1'b0;
   logic                           csr_pwrite      = 1'b0;
   logic [sed_pkg::CSR_ADDR_W-1:0] csr_paddr       = '0;
   logic [sed_pkg::CSR_DATA_W-1:0] csr_pwdata      = '0;
   logic [sed_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   edge_scoreboard sb = new();
   bit             calm = 1'b0;
   int unsigned    random_sent = 0;
   int unsigned    quiet_cycles = 0;

   sobel_edge_detect dut (.*);

   always #4 clock = ~clock;

   always @(negedge clock) rsp_stall <= !reset && !calm && ($urandom_range(99) < 11);

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result({rsp_edge_value, rsp_out_row, rsp_out_col, rsp_frame_last});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      @(negedge reset);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   task automatic write_csr(input sed_pkg::csr_reg_type r,
                            input logic [sed_pkg::CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= sed_pkg::CSR_ADDR_W'({r, 2'b00});
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      sb.write_reg(r, v);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_pixel(input logic [sed_pkg::PIX_W-1:0] pix, input bit fs);
      bit start;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      start = fs || sb.reads_unwritten(fs);
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= start;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_pixel(pix, start);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input bit write_all);
      int unsigned               w, h, t, n, sel, style, base;
      bit [2:0]                  mask;
      logic [sed_pkg::PIX_W-1:0] pix;
      sel = $urandom_range(99);
      w = (sel < 6) ? $urandom_range(0, 2) :
          (sel < 10) ? $urandom_range(1025, 2047) : $urandom_range(3, 14);
      sel = $urandom_range(99);
      h = (sel < 6) ? $urandom_range(0, 2) :
          (sel < 9) ? 65535 : $urandom_range(3, 8);
      sel = $urandom_range(99);
      t = (sel < 15) ? 0 : (sel < 25) ? 255 : $urandom_range(0, 120);
      mask = write_all ? 3'b111 : 3'($urandom_range(1, 7));
      if (mask[0]) write_csr(sed_pkg::REG_WIDTH, w);
      if (mask[1]) write_csr(sed_pkg::REG_HEIGHT, h);
      if (mask[2]) write_csr(sed_pkg::REG_THRESHOLD, t);
      w = sb.eff_width();
      h = sb.eff_height();
      if (w > 32)
         n = $urandom_range(10, 60);
      else if (h > 8)
         n = w * $urandom_range(3, 10);
      else
         n = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
      style = $urandom_range(2);
      base  = $urandom_range(255);
      for (int k = 0; k < n; k++) begin
         calm = (random_sent >= 300) && (random_sent < 550);
         case (style)
            0:       pix = sed_pkg::PIX_W'($urandom_range(255));
            1:       pix = $urandom_range(1) ? 8'hFF : 8'h00;
            default: pix = sed_pkg::PIX_W'((base + $urandom_range(0, 15)) % 256);
         endcase
         send_pixel(pix, (k == 0 && $urandom_range(3) != 0) || $urandom_range(39) == 0);
         random_sent++;
      end
      calm = 1'b0;
      drain();
   endtask

   initial begin
      logic [sed_pkg::PIX_W-1:0] square[16] = '{8'h00, 8'h00, 8'hFF, 8'hFF,
                                                8'h00, 8'h00, 8'hFF, 8'hFF,
                                                8'hFF, 8'hFF, 8'h00, 8'h00,
                                                8'h00, 8'hFF, 8'h00, 8'hFF};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(sed_pkg::REG_WIDTH, 4);
      write_csr(sed_pkg::REG_HEIGHT, 4);
      write_csr(sed_pkg::REG_THRESHOLD, 0);
      for (int i = 0; i < 16; i++) send_pixel(square[i], i == 0);
      drain();

      // The stream wraps to the next frame on its own here.
      write_csr(sed_pkg::REG_WIDTH, 3);
      write_csr(sed_pkg::REG_HEIGHT, 3);
      write_csr(sed_pkg::REG_THRESHOLD, 255);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'h00 : 8'hFF, 1'b0);
      drain();

      write_csr(sed_pkg::REG_WIDTH, WIDE_WIDTH);
      write_csr(sed_pkg::REG_HEIGHT, 3);
      write_csr(sed_pkg::REG_THRESHOLD, 40);
      for (int i = 0; i < 3 * WIDE_WIDTH; i++)
         send_pixel(sed_pkg::PIX_W'($urandom_range(255)), i == 0);
      drain();

      run_phase(1'b1);
      while (random_sent < RANDOM_ITEMS) run_phase(1'b0);

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2 * SETTLE) @(posedge clock);
      if (sb.pending.size() != 0)
         $display("%0d expected results never arrived", sb.pending.size());
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// File: sobel_edge_detect.f
src/sed_pkg.sv
src/sed_ram.sv
src/sobel_edge_detect.sv
verif/testbench.sv
